/* hw/rtl/hrhp_pkg.sv */
package hrhp_pkg;

    // Grammar positions
    localparam logic [4:0] ST_METHOD_START  = 5'd0;
    localparam logic [4:0] ST_METHOD        = 5'd1;
    localparam logic [4:0] ST_URI           = 5'd2;
    localparam logic [4:0] ST_VER_H         = 5'd3;
    localparam logic [4:0] ST_VER_T1        = 5'd4;
    localparam logic [4:0] ST_VER_T2        = 5'd5;
    localparam logic [4:0] ST_VER_P         = 5'd6;
    localparam logic [4:0] ST_VER_SLASH     = 5'd7;
    localparam logic [4:0] ST_MAJOR_START   = 5'd8;
    localparam logic [4:0] ST_MAJOR         = 5'd9;
    localparam logic [4:0] ST_MINOR_START   = 5'd10;
    localparam logic [4:0] ST_MINOR         = 5'd11;
    localparam logic [4:0] ST_NL_1          = 5'd12;
    localparam logic [4:0] ST_LINE_START    = 5'd13;
    localparam logic [4:0] ST_LWS           = 5'd14;
    localparam logic [4:0] ST_HNAME         = 5'd15;
    localparam logic [4:0] ST_SP_BEFORE_VAL = 5'd16;
    localparam logic [4:0] ST_HVALUE        = 5'd17;
    localparam logic [4:0] ST_NL_2          = 5'd18;
    localparam logic [4:0] ST_NL_3          = 5'd19;

    // Verdict codes
    localparam logic [1:0] V_MORE = 2'd0;
    localparam logic [1:0] V_DONE = 2'd1;
    localparam logic [1:0] V_BAD  = 2'd2;

    // Byte kinds
    localparam logic [2:0] K_DELIM  = 3'd0;
    localparam logic [2:0] K_METHOD = 3'd1;
    localparam logic [2:0] K_URI    = 3'd2;
    localparam logic [2:0] K_HNAME  = 3'd3;
    localparam logic [2:0] K_HVALUE = 3'd4;

    // Characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_LAST_CTL = 8'h1F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [7:0] ACC_MAX = 8'hFF;

    function automatic logic is_ctl(input logic [7:0] c);
        return (c <= CH_LAST_CTL) || (c == CH_DEL);
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic sep_char(input logic [7:0] c);
        logic r;
        unique case (c)
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
            8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20,
            8'h09: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Plain 7-bit character that is neither control nor separator
    function automatic logic is_token(input logic [7:0] c);
        return !c[7] && !is_ctl(c) && !sep_char(c);
    endfunction

    // Append one decimal digit, saturating at the top of the byte
    function automatic logic [7:0] acc_digit(input logic [7:0] acc, input logic [7:0] c);
        logic [11:0] v;
        v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {8'd0, c[3:0]};
        return (v > {4'd0, ACC_MAX}) ? ACC_MAX : v[7:0];
    endfunction

endpackage

/* hw/rtl/http_request_header_parser.sv */
// Byte-serial HTTP/1.x request parser. One request byte enters per item on
// s_tdata and one result item leaves per byte on m_tdata/m_tuser, tagging
// the byte (method, URI, header name, header value or delimiter), flagging
// the first byte of each header name, showing the version numbers parsed
// so far and giving a verdict: need more, complete or malformed. After a
// complete or malformed verdict the parser restarts at the method. The
// block sustains one item per cycle while m_tready does not hold back the
// output, through an input register, the single-step grammar transition
// and a result register; the grammar state register closes the only loop
// and updates once per item. Request strings are never stored; the consumer keeps any it needs.
module http_request_header_parser
    import hrhp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [1:0] verdict, [9:2] byte_out,
                                   // [17:10] version_major,
                                   // [25:18] version_minor, [31:26] zero
    output logic [3:0]  m_tuser    // [2:0] byte_kind, [3] header_begin
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic [1:0] verdict_reg;
    logic [2:0] kind_reg;
    logic [7:0] byte_reg;
    logic       hbeg_reg;

    logic [4:0] state_reg, state_next;
    logic       header_seen_reg, header_seen_next;
    logic [7:0] major_reg, major_next;
    logic [7:0] minor_reg, minor_next;

    logic [1:0] verdict_next;
    logic [2:0] kind_next;
    logic       hbeg_next;
    logic       advance;
    logic       s_accept;
    logic [7:0] c;

    // Move the held item to the result register when it is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign c        = in_byte_reg;

    // One grammar step
    always_comb begin
        logic [4:0] s;
        s                = state_reg;
        verdict_next     = V_MORE;
        kind_next        = K_DELIM;
        hbeg_next        = 1'b0;
        header_seen_next = header_seen_reg;
        major_next       = major_reg;
        minor_next       = minor_reg;
        unique case (state_reg)
            ST_METHOD_START: begin
                if (is_token(c)) begin
                    s = ST_METHOD; kind_next = K_METHOD;
                end else verdict_next = V_BAD;
            end
            ST_METHOD: begin
                if (c == CH_SP) s = ST_URI;
                else if (is_token(c)) kind_next = K_METHOD;
                else verdict_next = V_BAD;
            end
            ST_URI: begin
                if (c == CH_SP) s = ST_VER_H;
                else if (is_ctl(c)) verdict_next = V_BAD;
                else kind_next = K_URI;
            end
            ST_VER_H: begin
                if (c == CH_H) s = ST_VER_T1; else verdict_next = V_BAD;
            end
            ST_VER_T1: begin
                if (c == CH_T) s = ST_VER_T2; else verdict_next = V_BAD;
            end
            ST_VER_T2: begin
                if (c == CH_T) s = ST_VER_P; else verdict_next = V_BAD;
            end
            ST_VER_P: begin
                if (c == CH_P) s = ST_VER_SLASH; else verdict_next = V_BAD;
            end
            ST_VER_SLASH: begin
                if (c == CH_SLASH) begin
                    major_next = '0; minor_next = '0; s = ST_MAJOR_START;
                end else verdict_next = V_BAD;
            end
            ST_MAJOR_START: begin
                if (digit_char(c)) begin
                    major_next = acc_digit(major_reg, c); s = ST_MAJOR;
                end else verdict_next = V_BAD;
            end
            ST_MAJOR: begin
                if (c == CH_DOT) s = ST_MINOR_START;
                else if (digit_char(c)) major_next = acc_digit(major_reg, c);
                else verdict_next = V_BAD;
            end
            ST_MINOR_START: begin
                if (digit_char(c)) begin
                    minor_next = acc_digit(minor_reg, c); s = ST_MINOR;
                end else verdict_next = V_BAD;
            end
            ST_MINOR: begin
                if (c == CH_CR) s = ST_NL_1;
                else if (digit_char(c)) minor_next = acc_digit(minor_reg, c);
                else verdict_next = V_BAD;
            end
            ST_NL_1: begin
                if (c == CH_LF) s = ST_LINE_START; else verdict_next = V_BAD;
            end
            ST_LINE_START: begin
                priority if (c == CH_CR) s = ST_NL_3;
                else if (header_seen_reg && (c == CH_SP || c == CH_HT)) s = ST_LWS;
                else if (is_token(c)) begin
                    header_seen_next = 1'b1;
                    hbeg_next        = 1'b1;
                    kind_next        = K_HNAME;
                    s                = ST_HNAME;
                end else verdict_next = V_BAD;
            end
            ST_LWS: begin
                priority if (c == CH_CR) s = ST_NL_2;
                else if (c == CH_SP || c == CH_HT) s = ST_LWS;
                else if (is_ctl(c)) verdict_next = V_BAD;
                else begin
                    kind_next = K_HVALUE; s = ST_HVALUE;
                end
            end
            ST_HNAME: begin
                if (c == CH_COLON) s = ST_SP_BEFORE_VAL;
                else if (is_token(c)) kind_next = K_HNAME;
                else verdict_next = V_BAD;
            end
            ST_SP_BEFORE_VAL: begin
                if (c == CH_SP) s = ST_HVALUE; else verdict_next = V_BAD;
            end
            ST_HVALUE: begin
                if (c == CH_CR) s = ST_NL_2;
                else if (is_ctl(c)) verdict_next = V_BAD;
                else kind_next = K_HVALUE;
            end
            ST_NL_2: begin
                if (c == CH_LF) s = ST_LINE_START; else verdict_next = V_BAD;
            end
            ST_NL_3: begin
                verdict_next = (c == CH_LF) ? V_DONE : V_BAD;
            end
            default: begin
                verdict_next = V_BAD;
            end
        endcase
        // Restart after any verdict
        if (verdict_next != V_MORE) begin
            s                = ST_METHOD_START;
            header_seen_next = 1'b0;
        end
        state_next = s;
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (s_accept) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Grammar state, advanced once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_METHOD_START;
            header_seen_reg <= 1'b0;
            major_reg       <= '0;
            minor_reg       <= '0;
        end else if (advance) begin
            state_reg       <= state_next;
            header_seen_reg <= header_seen_next;
            major_reg       <= major_next;
            minor_reg       <= minor_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            verdict_reg <= verdict_next;
            kind_reg    <= kind_next;
            byte_reg    <= in_byte_reg;
            hbeg_reg    <= hbeg_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, minor_reg, major_reg, byte_reg, verdict_reg};
    assign m_tuser  = {hbeg_reg, kind_reg};

`ifndef ASSERT_OFF
    // A verdict restarts the grammar
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (verdict_next != V_MORE)
        |=> (state_reg == ST_METHOD_START) && !header_seen_reg)
        else $error("parser did not restart after a verdict");

    // A header start is always a header name byte
    a_hbeg_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |-> (m_tuser[2:0] == K_HNAME))
        else $error("header start on a non-name byte");

    // Completion only comes on the final delimiter
    a_done_delim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == V_DONE) |-> (m_tuser[2:0] == K_DELIM)
            && (m_tdata[9:2] == CH_LF))
        else $error("request completed on a wrong byte");

    // Grammar state holds while no item advances
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("grammar state moved without an item");
`endif

endmodule
